// ----- sv/lsfp_pkg.sv -----
// Shared types and constants for the lidar serial frame parser.
`default_nettype none

package lsfp_pkg;

    localparam logic [7:0]  HDR_BYTE       = 8'h59;
    localparam logic [15:0] FALLBACK_RESET = 16'd100;

    typedef enum logic [3:0] {
        PH_HUNT = 4'd0,
        PH_HDR2 = 4'd1,
        PH_PAY0 = 4'd2,
        PH_PAY1 = 4'd3,
        PH_PAY2 = 4'd4,
        PH_PAY3 = 4'd5,
        PH_PAY4 = 4'd6,
        PH_PAY5 = 4'd7,
        PH_PAY6 = 4'd8
    } phase_t;

    typedef struct packed {
        logic [15:0] frame_distance;
        logic        checksum_ok;
        logic [15:0] held_distance;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/lidar_serial_frame_parser_unit.sv -----
// Top level of the lidar serial frame parser: input register, parser and result register.
//
// Received serial bytes enter one per cycle through a registered input stage. The byte is
// parsed from that register. When it closes a nine-byte frame (two 0x59 headers and
// seven payload bytes), its result is loaded into the output register at the end of the
// cycle in which that byte leaves the parser, which raises out_valid.
// The block sustains one byte per clock; the only thing that slows it is a result that
// waits in the output register while the parser holds another closing byte. Each result
// carries the frame's distance, the checksum verdict and the held distance (latest good
// nonzero distance, or fallback_distance until one arrives). fallback_distance resets to
// 100 and is written through its own channel, which is always ready; write it while idle.
`default_nettype none

module lidar_serial_frame_parser_unit
    import lsfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] fallback_distance,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      frame_distance,
    output logic             checksum_ok,
    output logic [15:0]      held_distance
);

    logic [15:0] fallback_reg;
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     parse_result;
    logic        frame_done;
    logic        out_free;
    logic        s1_advance;
    logic        in_xfer;

    assign cfg_ready  = 1'b1;
    assign out_free   = !out_valid_reg || out_ready;
    // A byte that closes a frame can only leave once the result register is free.
    assign s1_advance = s1_valid_reg && (!frame_done || out_free);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_xfer    = in_valid && in_ready;

    lsfp_parser u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (s1_advance),
        .rx_byte           (s1_byte_reg),
        .fallback_distance (fallback_reg),
        .frame_done        (frame_done),
        .result            (parse_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fallback_reg <= FALLBACK_RESET;
        end
        else if (cfg_valid)
        begin
            fallback_reg <= fallback_distance;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance && frame_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (s1_advance && frame_done)
        begin
            out_reg <= parse_result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_distance = out_reg.frame_distance;
    assign checksum_ok    = out_reg.checksum_ok;
    assign held_distance  = out_reg.held_distance;

endmodule

`default_nettype wire

// ----- sv/lsfp_parser.sv -----
// Frame parser state machine: header hunt, payload collection and checksum.
`default_nettype none

module lsfp_parser
    import lsfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [15:0] fallback_distance,
    output logic             frame_done,
    output result_t          result
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] dist_reg, dist_next;
    logic [15:0] last_good_reg, last_good_next;
    logic        sum_match;
    logic        new_good;

    assign sum_match = (sum_reg == rx_byte);
    assign new_good  = sum_match && (dist_reg != 16'd0);

    // Next state.
    always_comb
    begin
        phase_next     = phase_reg;
        sum_next       = sum_reg;
        dist_next      = dist_reg;
        last_good_next = last_good_reg;
        case (phase_reg)
            PH_HDR2:
            begin
                if (rx_byte == HDR_BYTE)
                begin
                    sum_next   = 8'(HDR_BYTE + HDR_BYTE);
                    dist_next  = 16'd0;
                    phase_next = PH_PAY0;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_PAY0:
            begin
                dist_next  = {dist_reg[15:8], rx_byte};
                sum_next   = sum_reg + rx_byte;
                phase_next = PH_PAY1;
            end
            PH_PAY1:
            begin
                dist_next  = {rx_byte, dist_reg[7:0]};
                sum_next   = sum_reg + rx_byte;
                phase_next = PH_PAY2;
            end
            PH_PAY2:
            begin
                sum_next   = sum_reg + rx_byte;
                phase_next = PH_PAY3;
            end
            PH_PAY3:
            begin
                sum_next   = sum_reg + rx_byte;
                phase_next = PH_PAY4;
            end
            PH_PAY4:
            begin
                sum_next   = sum_reg + rx_byte;
                phase_next = PH_PAY5;
            end
            PH_PAY5:
            begin
                sum_next   = sum_reg + rx_byte;
                phase_next = PH_PAY6;
            end
            PH_PAY6:
            begin
                if (new_good)
                begin
                    last_good_next = dist_reg;
                end
                phase_next = PH_HUNT;
            end
            default:
            begin
                // Hunting; a byte rejected as second header lands here and is not re-checked.
                phase_next = (rx_byte == HDR_BYTE) ? PH_HDR2 : PH_HUNT;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        frame_done            = (phase_reg == PH_PAY6);
        result.frame_distance = dist_reg;
        result.checksum_ok    = sum_match;
        if (new_good)
        begin
            result.held_distance = dist_reg;
        end
        else if (last_good_reg != 16'd0)
        begin
            result.held_distance = last_good_reg;
        end
        else
        begin
            result.held_distance = fallback_distance;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            sum_reg       <= 8'd0;
            dist_reg      <= 16'd0;
            last_good_reg <= 16'd0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            dist_reg      <= dist_next;
            last_good_reg <= last_good_next;
        end
    end

endmodule

`default_nettype wire
